// ===== hdl/edq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edq_pkg
// Shared codes and types for the event dispatch queue.
// ----------------------------------------------------------------------------
package edq_pkg;

	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 3;
	localparam int HANDLER_W = 8;
	localparam int SUBIDX_W  = 4;
	localparam int EVOUT_W   = 8;

	localparam logic [MODE_W-1:0] MODE_SUBSCRIBE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_EMIT      = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK      = 2'd2;

	localparam logic [STATUS_W-1:0] ST_ACCEPTED   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOTHING    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SCAN
	} edq_state_t;

	// control part of the probe walking down the cell row
	typedef struct packed {
		logic active;
		logic found;
	} edq_probe_ctl_t;

endpackage

// ===== hdl/edq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edq_cell
// One subscription slot; compares the passing probe and hands it on.
// ----------------------------------------------------------------------------
module edq_cell #(
	parameter int CELL_IDX = 0,
	parameter int ID_BITS  = 8,
	parameter int IDX_W    = 4,
	parameter int CNT_W    = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [ID_BITS-1:0]            wr_event,
	input  logic [edq_pkg::HANDLER_W-1:0] wr_handler,
	input  logic [CNT_W-1:0]              sub_count,
	input  logic [CNT_W-1:0]              start_pos,
	input  edq_pkg::edq_probe_ctl_t       ctl_in,
	input  logic [ID_BITS-1:0]            ev_in,
	input  logic [IDX_W-1:0]              idx_in,
	input  logic [edq_pkg::HANDLER_W-1:0] hd_in,
	output edq_pkg::edq_probe_ctl_t       ctl_out,
	output logic [ID_BITS-1:0]            ev_out,
	output logic [IDX_W-1:0]              idx_out,
	output logic [edq_pkg::HANDLER_W-1:0] hd_out
);

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [ID_BITS-1:0]            entry_ev_q;
	logic [edq_pkg::HANDLER_W-1:0] entry_hd_q;
	edq_pkg::edq_probe_ctl_t       ctl_q;
	logic [ID_BITS-1:0]            ev_q;
	logic [IDX_W-1:0]              idx_q;
	logic [edq_pkg::HANDLER_W-1:0] hd_q;
	logic                          hit;

	// slot is live only below the fill count, and only from the resume point on
	assign hit = ctl_in.active && !ctl_in.found && (MY_POS >= start_pos) &&
	             (MY_POS < sub_count) && (entry_ev_q == ev_in);

	always_ff @(posedge clk) begin
		if (wr_en && (sub_count == MY_POS)) begin
			entry_ev_q <= wr_event;
			entry_hd_q <= wr_handler;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.active <= ctl_in.active;
			ctl_q.found  <= ctl_in.found | hit;
		end
	end

	always_ff @(posedge clk) begin
		ev_q  <= ev_in;
		idx_q <= hit ? MY_IDX : idx_in;
		hd_q  <= hit ? entry_hd_q : hd_in;
	end

	assign ctl_out = ctl_q;
	assign ev_out  = ev_q;
	assign idx_out = idx_q;
	assign hd_out  = hd_q;

endmodule

// ===== hdl/edq_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edq_fifo
// Circular event queue with registered read data.
// ----------------------------------------------------------------------------
module edq_fifo #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [WIDTH-1:0] rd_data_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
		if (pop) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			// push and pop never come in the same cycle
			if (push) begin
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/event_dispatch_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_dispatch_queue
// Publish-subscribe dispatcher: subscription table in a row of cells,
// emitted events in a queue, at most one handler dispatched per tick.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item yields one
// result, shown on the result ports for a single cycle while done is high.
// The receiver cannot stall, so results must be captured the cycle they
// appear. Subscribe, emit, an idle tick and mode three answer in the cycle
// after acceptance. A tick that searches the table sends a probe down the row
// of ENTRIES cells, one cell per cycle, and answers when the probe leaves the
// last cell, after first popping a new event off the queue if it has none.
// ----------------------------------------------------------------------------
module event_dispatch_queue #(
	parameter int ENTRIES = 16,
	parameter int ID_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [edq_pkg::MODE_W-1:0]    mode,
	input  logic [ID_BITS-1:0]            event_id,
	input  logic [edq_pkg::HANDLER_W-1:0] handler_id,
	output logic                          done,
	output logic [edq_pkg::STATUS_W-1:0]  status,
	output logic [edq_pkg::SUBIDX_W-1:0]  subscriber_index,
	output logic [edq_pkg::HANDLER_W-1:0] handler_out,
	output logic [edq_pkg::EVOUT_W-1:0]   event_out
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int EV_EXT_W  = (ID_BITS > edq_pkg::EVOUT_W) ? ID_BITS : edq_pkg::EVOUT_W;
	localparam int IDX_EXT_W = (IDX_W > edq_pkg::SUBIDX_W) ? IDX_W : edq_pkg::SUBIDX_W;
	localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(ENTRIES);

	edq_pkg::edq_state_t state_q, state_d;

	logic             accept;
	logic             launch;
	logic             sub_wr;
	logic             fifo_push;
	logic             fifo_pop;
	logic             fifo_full;
	logic             fifo_empty;
	logic [ID_BITS-1:0] fifo_rd_data;

	logic [CNT_W-1:0]   sub_count_q;
	logic [ID_BITS-1:0] cur_event_q;
	logic               cur_valid_q;
	logic [CNT_W-1:0]   search_pos_q;
	logic [ID_BITS-1:0] launch_event;

	logic                          done_q;
	logic [edq_pkg::STATUS_W-1:0]  status_q;
	logic [edq_pkg::SUBIDX_W-1:0]  sub_idx_q;
	logic [edq_pkg::HANDLER_W-1:0] handler_q;
	logic [edq_pkg::EVOUT_W-1:0]   event_q;

	edq_pkg::edq_probe_ctl_t       pr_ctl [ENTRIES+1];
	logic [ID_BITS-1:0]            pr_ev  [ENTRIES+1];
	logic [IDX_W-1:0]              pr_idx [ENTRIES+1];
	logic [edq_pkg::HANDLER_W-1:0] pr_hd  [ENTRIES+1];

	logic [EV_EXT_W-1:0]  tail_ev_ext;
	logic [IDX_EXT_W-1:0] tail_idx_ext;

	assign accept = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			edq_pkg::S_IDLE: begin
				if (accept && (mode == edq_pkg::MODE_TICK)) begin
					if (cur_valid_q) begin
						state_d = edq_pkg::S_SCAN;
					end else if (!fifo_empty) begin
						state_d = edq_pkg::S_POP;
					end
				end
			end
			edq_pkg::S_POP: begin
				state_d = edq_pkg::S_SCAN;
			end
			edq_pkg::S_SCAN: begin
				if (pr_ctl[ENTRIES].active) begin
					state_d = edq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = edq_pkg::S_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		busy         = 1'b1;
		launch       = 1'b0;
		launch_event = cur_event_q;
		case (state_q)
			edq_pkg::S_IDLE: begin
				busy   = 1'b0;
				launch = accept && (mode == edq_pkg::MODE_TICK) && cur_valid_q;
			end
			edq_pkg::S_POP: begin
				launch       = 1'b1;
				launch_event = fifo_rd_data;
			end
			edq_pkg::S_SCAN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign sub_wr    = accept && (mode == edq_pkg::MODE_SUBSCRIBE) && (sub_count_q != TABLE_FULL);
	assign fifo_push = accept && (mode == edq_pkg::MODE_EMIT) && !fifo_full;
	assign fifo_pop  = accept && (mode == edq_pkg::MODE_TICK) && !cur_valid_q && !fifo_empty;

	edq_fifo #(
		.DEPTH(ENTRIES),
		.WIDTH(ID_BITS)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fifo_push),
		.push_data(event_id),
		.pop      (fifo_pop),
		.pop_data (fifo_rd_data),
		.full     (fifo_full),
		.empty    (fifo_empty)
	);

	assign pr_ctl[0].active = launch;
	assign pr_ctl[0].found  = 1'b0;
	assign pr_ev[0]  = launch_event;
	assign pr_idx[0] = '0;
	assign pr_hd[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		edq_cell #(
			.CELL_IDX(i),
			.ID_BITS (ID_BITS),
			.IDX_W   (IDX_W),
			.CNT_W   (CNT_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (sub_wr),
			.wr_event  (event_id),
			.wr_handler(handler_id),
			.sub_count (sub_count_q),
			.start_pos (search_pos_q),
			.ctl_in    (pr_ctl[i]),
			.ev_in     (pr_ev[i]),
			.idx_in    (pr_idx[i]),
			.hd_in     (pr_hd[i]),
			.ctl_out   (pr_ctl[i+1]),
			.ev_out    (pr_ev[i+1]),
			.idx_out   (pr_idx[i+1]),
			.hd_out    (pr_hd[i+1])
		);
	end

	assign tail_ev_ext  = EV_EXT_W'(pr_ev[ENTRIES]);
	assign tail_idx_ext = IDX_EXT_W'(pr_idx[ENTRIES]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= edq_pkg::S_IDLE;
			sub_count_q  <= '0;
			cur_event_q  <= '0;
			cur_valid_q  <= 1'b0;
			search_pos_q <= '0;
			done_q       <= 1'b0;
			status_q     <= edq_pkg::ST_ACCEPTED;
			sub_idx_q    <= '0;
			handler_q    <= '0;
			event_q      <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (sub_wr) begin
				sub_count_q <= sub_count_q + 1'b1;
			end
			if (fifo_pop) begin
				search_pos_q <= '0;
			end
			if (state_q == edq_pkg::S_POP) begin
				cur_event_q <= fifo_rd_data;
				cur_valid_q <= 1'b1;
			end

			if (accept && !launch && !fifo_pop) begin
				done_q    <= 1'b1;
				sub_idx_q <= '0;
				handler_q <= '0;
				event_q   <= '0;
				case (mode)
					edq_pkg::MODE_SUBSCRIBE: begin
						status_q <= sub_wr ? edq_pkg::ST_ACCEPTED : edq_pkg::ST_TABLE_FULL;
					end
					edq_pkg::MODE_EMIT: begin
						status_q <= fifo_push ? edq_pkg::ST_ACCEPTED : edq_pkg::ST_QUEUE_FULL;
					end
					default: begin
						status_q <= edq_pkg::ST_NOTHING;
					end
				endcase
			end

			if ((state_q == edq_pkg::S_SCAN) && pr_ctl[ENTRIES].active) begin
				done_q <= 1'b1;
				if (pr_ctl[ENTRIES].found) begin
					status_q     <= edq_pkg::ST_DISPATCHED;
					sub_idx_q    <= tail_idx_ext[edq_pkg::SUBIDX_W-1:0];
					handler_q    <= pr_hd[ENTRIES];
					event_q      <= tail_ev_ext[edq_pkg::EVOUT_W-1:0];
					search_pos_q <= CNT_W'(pr_idx[ENTRIES]) + 1'b1;
				end else begin
					// no further subscriber: drop the current event
					status_q     <= edq_pkg::ST_NOTHING;
					sub_idx_q    <= '0;
					handler_q    <= '0;
					event_q      <= '0;
					search_pos_q <= '0;
					cur_valid_q  <= 1'b0;
					cur_event_q  <= '0;
				end
			end
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign subscriber_index = sub_idx_q;
	assign handler_out      = handler_q;
	assign event_out        = event_q;

endmodule

// ===== bench/tb_event_dispatch_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_dispatch_queue
// Self-checking bench for the event dispatch queue: subscribe, emit and tick
// items go in through the start/busy handshake, each done strobe is checked
// against an in-bench model of the subscription table, event queue and scan.
// ----------------------------------------------------------------------------
module tb_event_dispatch_queue;

	localparam int SLOTS        = 16;
	localparam int ID_W         = 8;
	localparam int MD_W         = edq_pkg::MODE_W;
	localparam int HD_W         = edq_pkg::HANDLER_W;
	localparam int RAND_ITEMS   = 1700;
	localparam int LIMIT_CYCLES = 400000;

	localparam logic [MD_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [edq_pkg::STATUS_W-1:0]  status;
		logic [edq_pkg::SUBIDX_W-1:0]  index;
		logic [edq_pkg::HANDLER_W-1:0] handler;
		logic [edq_pkg::EVOUT_W-1:0]   evt;
	} dispatch_outcome_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [MD_W-1:0]               mode;
	logic [ID_W-1:0]               event_id;
	logic [HD_W-1:0]               handler_id;
	logic                          done;
	logic [edq_pkg::STATUS_W-1:0]  status;
	logic [edq_pkg::SUBIDX_W-1:0]  subscriber_index;
	logic [edq_pkg::HANDLER_W-1:0] handler_out;
	logic [edq_pkg::EVOUT_W-1:0]   event_out;

	// model state
	logic [ID_W-1:0]      tbl_event [SLOTS];
	logic [HD_W-1:0]      tbl_handler [SLOTS];
	int                   sub_total;
	logic [ID_W-1:0]      queued_events [$];
	logic [ID_W-1:0]      cur_event;
	logic                 cur_valid;
	int                   scan_pos;

	dispatch_outcome_t    outcome_fifo [$];
	int                   mismatches;
	int                   cycles;
	int                   burst_left;

	event_dispatch_queue #(
		.ENTRIES(SLOTS),
		.ID_BITS(ID_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.event_id(event_id),
		.handler_id(handler_id),
		.done(done),
		.status(status),
		.subscriber_index(subscriber_index),
		.handler_out(handler_out),
		.event_out(event_out)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic dispatch_outcome_t dispatcher_step(input logic [MD_W-1:0] m,
			input logic [ID_W-1:0] ev, input logic [HD_W-1:0] hd);
		dispatch_outcome_t r;
		int pos;
		bit hit;
		r = '0;
		r.status = edq_pkg::ST_NOTHING;
		hit = 1'b0;
		case (m)
			edq_pkg::MODE_SUBSCRIBE: begin
				if (sub_total >= SLOTS) begin
					r.status = edq_pkg::ST_TABLE_FULL;
				end else begin
					tbl_event[sub_total] = ev;
					tbl_handler[sub_total] = hd;
					sub_total++;
					r.status = edq_pkg::ST_ACCEPTED;
				end
			end
			edq_pkg::MODE_EMIT: begin
				if (queued_events.size() >= SLOTS) begin
					r.status = edq_pkg::ST_QUEUE_FULL;
				end else begin
					queued_events.push_back(ev);
					r.status = edq_pkg::ST_ACCEPTED;
				end
			end
			edq_pkg::MODE_TICK: begin
				if (!cur_valid && queued_events.size() > 0) begin
					cur_event = queued_events.pop_front();
					cur_valid = 1'b1;
					scan_pos = 0;
				end
				if (cur_valid) begin
					for (pos = scan_pos; pos < sub_total && !hit; pos++) begin
						if (tbl_event[pos] == cur_event) begin
							hit = 1'b1;
							scan_pos = pos + 1;
							r.status = edq_pkg::ST_DISPATCHED;
							r.index = pos[edq_pkg::SUBIDX_W-1:0];
							r.handler = tbl_handler[pos];
							r.evt = cur_event;
						end
					end
					if (!hit) begin
						// scan ran off the end: event is finished
						scan_pos = 0;
						cur_valid = 1'b0;
						cur_event = '0;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk) begin : check_results
		dispatch_outcome_t want;
		if (arst_n && done) begin
			if (outcome_fifo.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0d",
					$time, status);
				mismatches++;
			end else begin
				want = outcome_fifo.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					mismatches++;
				end
				if (subscriber_index !== want.index) begin
					$display("%0t: subscriber_index expected %0d actual %0d",
						$time, want.index, subscriber_index);
					mismatches++;
				end
				if (handler_out !== want.handler) begin
					$display("%0t: handler_out expected %0d actual %0d",
						$time, want.handler, handler_out);
					mismatches++;
				end
				if (event_out !== want.evt) begin
					$display("%0t: event_out expected %0d actual %0d",
						$time, want.evt, event_out);
					mismatches++;
				end
			end
		end
	end

	// sender pacing: bursts back to back, random gaps between bursts
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 20);
			start <= 1'b0;
			mode <= MD_W'($urandom_range(0, 3));
			event_id <= ID_W'($urandom_range(0, 255));
			handler_id <= HD_W'($urandom_range(0, 255));
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 8);
		end
	endtask

	task automatic send_item(input logic [MD_W-1:0] m, input logic [ID_W-1:0] ev,
			input logic [HD_W-1:0] hd);
		start <= 1'b1;
		mode <= m;
		event_id <= ev;
		handler_id <= hd;
		@(posedge clk);
		while (busy) @(posedge clk);
		outcome_fifo.push_back(dispatcher_step(m, ev, hd));
		pace();
	endtask

	function automatic logic [ID_W-1:0] pick_event();
		logic [ID_W-1:0] pool [5];
		pool = '{8'h00, 8'hFF, 8'h11, 8'h42, 8'h80};
		if ($urandom_range(0, 9) < 7)
			return pool[$urandom_range(0, 4)];
		return ID_W'($urandom_range(0, 255));
	endfunction

	task automatic drain_dispatch();
		while (cur_valid || queued_events.size() > 0)
			send_item(edq_pkg::MODE_TICK, ID_W'($urandom_range(0, 255)),
				HD_W'($urandom_range(0, 255)));
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
	endtask

	task automatic test_directed();
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);       // idle tick
		send_item(MODE_UNUSED, 8'hFF, 8'hFF);              // unused mode is ignored
		send_item(edq_pkg::MODE_EMIT, 8'h07, 8'h00);       // no subscribers
		send_item(edq_pkg::MODE_TICK, 8'hFF, 8'hFF);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_SUBSCRIBE, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_SUBSCRIBE, 8'hFF, 8'hFF);
		send_item(edq_pkg::MODE_SUBSCRIBE, 8'h00, 8'hA5);
		send_item(edq_pkg::MODE_EMIT, 8'h00, 8'hFF);       // event id zero is ordinary
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_EMIT, 8'hFF, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
	endtask

	task automatic test_subscribe_mid_dispatch();
		send_item(edq_pkg::MODE_EMIT, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_SUBSCRIBE, 8'h00, 8'h3C);  // lands past the scan position
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_TICK, 8'h00, 8'h00);
	endtask

	task automatic test_queue_full();
		int i;
		for (i = 0; i < SLOTS + 1; i++)
			send_item(edq_pkg::MODE_EMIT, (i % 3 == 0) ? 8'hFF : i[7:0] & 8'h01, 8'h00);
		send_item(edq_pkg::MODE_EMIT, 8'h00, 8'h00);
		drain_dispatch();
	endtask

	task automatic test_random_traffic();
		int n;
		int pick;
		int i;
		n = 0;
		while (n < RAND_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				// emit burst to run the queue into its limit
				for (i = 0; i < SLOTS + 2; i++)
					send_item(edq_pkg::MODE_EMIT, pick_event(),
						HD_W'($urandom_range(0, 255)));
				n += SLOTS + 2;
			end else if (pick < 8) begin
				send_item(edq_pkg::MODE_SUBSCRIBE, pick_event(),
					HD_W'($urandom_range(0, 255)));
				n++;
			end else if (pick < 36) begin
				send_item(edq_pkg::MODE_EMIT, pick_event(), HD_W'($urandom_range(0, 255)));
				n++;
			end else if (pick < 96) begin
				send_item(edq_pkg::MODE_TICK, ID_W'($urandom_range(0, 255)),
					HD_W'($urandom_range(0, 255)));
				n++;
			end else begin
				send_item(MODE_UNUSED, ID_W'($urandom_range(0, 255)),
					HD_W'($urandom_range(0, 255)));
			end
		end
		drain_dispatch();
	endtask

	task automatic test_table_full();
		while (sub_total < SLOTS)
			send_item(edq_pkg::MODE_SUBSCRIBE, pick_event(), HD_W'($urandom_range(0, 255)));
		send_item(edq_pkg::MODE_SUBSCRIBE, 8'hFF, 8'hFF);
		send_item(edq_pkg::MODE_SUBSCRIBE, 8'h00, 8'h00);
		send_item(edq_pkg::MODE_EMIT, 8'h42, 8'h00);
		drain_dispatch();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = edq_pkg::MODE_TICK;
		event_id = '0;
		handler_id = '0;
		sub_total = 0;
		cur_event = '0;
		cur_valid = 1'b0;
		scan_pos = 0;
		mismatches = 0;
		cycles = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_subscribe_mid_dispatch();
		test_queue_full();
		test_random_traffic();
		test_table_full();

		start <= 1'b0;
		while (outcome_fifo.size() != 0) @(posedge clk);
		repeat (SLOTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/edq_pkg.sv
hdl/edq_cell.sv
hdl/edq_fifo.sv
hdl/event_dispatch_queue.sv
bench/tb_event_dispatch_queue.sv
